// ===== rtl/axis_position_limit_guard_macros.svh =====
// Assertion macros for the checker file of the limit guard.
// No dependencies; include by bare file name.
`ifndef AXIS_POSITION_LIMIT_GUARD_MACROS_SVH
`define AXIS_POSITION_LIMIT_GUARD_MACROS_SVH

// same-cycle implication
`define APLG_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("aplg assertion failed");

// next-cycle implication
`define APLG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("aplg assertion failed");

`endif

// ===== rtl/aplg_pkg.sv =====
// Types, codes and constants for the axis position limit guard.
// No dependencies; imported by every module of the block.
package aplg_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_STEP = 2'd0,
    OP_POLL = 2'd1,
    OP_MOVE = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  localparam logic [1:0] LIM_NONE = 2'd0;
  localparam logic [1:0] LIM_UP   = 2'd1;
  localparam logic [1:0] LIM_DN   = 2'd2;

  localparam logic [1:0] MODE_SHARED   = 2'd1;
  localparam logic [1:0] MODE_SEPARATE = 2'd2;

  localparam logic [2:0] REG_SOFT_MIN        = 3'd0;
  localparam logic [2:0] REG_SOFT_MAX        = 3'd1;
  localparam logic [2:0] REG_SOFT_ENABLE     = 3'd2;
  localparam logic [2:0] REG_HARD_MIN        = 3'd3;
  localparam logic [2:0] REG_HARD_MAX        = 3'd4;
  localparam logic [2:0] REG_LIMIT_MODE      = 3'd5;
  localparam logic [2:0] REG_ACTIVE_LEVEL    = 3'd6;
  localparam logic [2:0] REG_SWITCHES_FITTED = 3'd7;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] target_pos;
    logic               clamp_on_soft;
    logic               up_level;
    logic               down_level;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [31:0]        steps_left;
    logic               moving_up;
    logic               accepted;
    logic [1:0]         limit_hit;
    logic [31:0]        steps_cut;
  } out_t;

  typedef struct packed {
    logic signed [31:0] soft_min;
    logic signed [31:0] soft_max;
    logic               soft_enable;
    logic signed [31:0] hard_min;
    logic signed [31:0] hard_max;
    logic [1:0]         limit_mode;
    logic               active_level;
    logic [1:0]         switches_fitted;
  } cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    op_t         op;
    logic [31:0] tgt;     // move target after soft clamp, or new position
    logic        ok;      // move not refused by soft limits
    logic        shared;  // shared-switch mode selected
    logic        sw_cur;  // shared switch triggered
    logic        sep_up;  // separate mode: up switch fitted and triggered
    logic        sep_dn;
  } cmd_t;

endpackage

// ===== rtl/aplg_front.sv =====
// Front end: takes items, applies the soft-limit check and decodes switches.
// Depends on aplg_pkg.
module aplg_front (
  input  aplg_pkg::in_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  aplg_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           q_push,
  output aplg_pkg::cmd_t q_wdata
);
  import aplg_pkg::*;

  logic above_max, below_min, is_move;

  assign cmd_stall = q_full;
  assign q_push    = cmd_valid && !q_full;

  assign above_max = !(cmd.target_pos < cfg.soft_max);
  assign below_min = !(cfg.soft_min < cmd.target_pos);
  // soft limits only bound absolute moves, never a position set
  assign is_move   = (cmd.operation == OP_MOVE);

  always_comb begin
    q_wdata        = '0;
    q_wdata.op     = cmd.operation;
    q_wdata.tgt    = cmd.target_pos;
    q_wdata.ok     = 1'b1;
    // upper test first, so inverted limits resolve toward soft_max
    if (is_move && cfg.soft_enable && above_max) begin
      q_wdata.tgt = cfg.soft_max;
      q_wdata.ok  = cmd.clamp_on_soft;
    end else if (is_move && cfg.soft_enable && below_min) begin
      q_wdata.tgt = cfg.soft_min;
      q_wdata.ok  = cmd.clamp_on_soft;
    end
    q_wdata.shared = (cfg.limit_mode == MODE_SHARED);
    q_wdata.sw_cur = (cmd.up_level == cfg.active_level);
    q_wdata.sep_up = (cfg.limit_mode == MODE_SEPARATE) && cfg.switches_fitted[0]
                     && (cmd.up_level == cfg.active_level);
    q_wdata.sep_dn = (cfg.limit_mode == MODE_SEPARATE) && cfg.switches_fitted[1]
                     && (cmd.down_level == cfg.active_level);
  end

endmodule

// ===== rtl/aplg_fifo.sv =====
// Short queue of classified items between front and back end.
// Depends on aplg_pkg.
module aplg_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aplg_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output aplg_pkg::cmd_t rdata
);
  import aplg_pkg::*;

  cmd_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full   = (count == QCNT_W'(QDEPTH));
  assign rvalid = (count != '0);
  assign rdata  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/aplg_back.sv =====
// Back end: owns position and move state, executes one item per cycle while
// the result is not stalled, holds the result register. Depends on aplg_pkg.
module aplg_back #(
  parameter int POS_WIDTH = aplg_pkg::POS_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  aplg_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  aplg_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_stall,
  output aplg_pkg::out_t res
);
  import aplg_pkg::*;

  localparam int PW = POS_WIDTH;

  logic [PW-1:0]    pos, pos_next;
  logic [31:0]      rem, rem_next;
  logic             dir, dir_next;
  logic             prev_sw, prev_sw_next;
  logic [1:0]       last_lim, last_lim_next;
  out_t             res_next;

  logic [PW+31:0]   tgt_x, hmax_x, hmin_x, pos_x, mag_x;
  logic [PW-1:0]    tgt_w, mag;
  logic [PW:0]      d_up, d_dn;
  logic             go_down, sat, busy, want_up, want_dn;
  logic [31:0]      mv_rem;

  assign q_pop = q_valid && (!res_valid || !res_stall);
  assign busy  = (rem != '0);

  // 32-bit values wrap or sign-extend to the position width
  assign tgt_x  = {{PW{q_data.tgt[31]}}, q_data.tgt};
  assign hmax_x = {{PW{cfg.hard_max[31]}}, cfg.hard_max};
  assign hmin_x = {{PW{cfg.hard_min[31]}}, cfg.hard_min};
  assign tgt_w  = tgt_x[PW-1:0];

  // distance to target, both signs in parallel, saturated to 32 bits
  assign d_up    = {tgt_w[PW-1], tgt_w} - {pos[PW-1], pos};
  assign d_dn    = {pos[PW-1], pos} - {tgt_w[PW-1], tgt_w};
  assign go_down = d_up[PW];
  assign mag     = go_down ? d_dn[PW-1:0] : d_up[PW-1:0];
  assign mag_x   = {32'd0, mag};
  assign sat     = |mag_x[PW+31:32];
  assign mv_rem  = sat ? '1 : mag_x[31:0];

  always_comb begin
    want_up = q_data.sep_up;
    want_dn = q_data.sep_dn;
    if (q_data.shared) begin
      want_up = 1'b0;
      want_dn = 1'b0;
      if (q_data.sw_cur && !prev_sw) begin
        want_up = dir;
        want_dn = !dir;
      end else if (q_data.sw_cur) begin
        // held switch: repeat the last stop
        want_up = (last_lim == LIM_UP);
        want_dn = (last_lim == LIM_DN);
      end
    end
  end

  always_comb begin
    pos_next      = pos;
    rem_next      = rem;
    dir_next      = dir;
    prev_sw_next  = prev_sw;
    last_lim_next = last_lim;
    res_next      = '0;
    unique case (q_data.op)
      OP_STEP: begin
        if (busy) begin
          rem_next = rem - 1'b1;
          pos_next = dir ? pos + 1'b1 : pos - 1'b1;
        end
      end
      OP_POLL: begin
        if (q_data.shared) begin
          prev_sw_next = q_data.sw_cur;
        end
        if (want_up && busy && dir) begin
          res_next.steps_cut = rem;
          res_next.limit_hit = LIM_UP;
          rem_next           = '0;
          pos_next           = hmax_x[PW-1:0];
          last_lim_next      = LIM_UP;
        end else if (want_dn && busy && !dir) begin
          res_next.steps_cut = rem;
          res_next.limit_hit = LIM_DN;
          rem_next           = '0;
          pos_next           = hmin_x[PW-1:0];
          last_lim_next      = LIM_DN;
        end
      end
      OP_MOVE: begin
        res_next.accepted = q_data.ok;
        if (q_data.ok) begin
          dir_next = !go_down;
          rem_next = mv_rem;
        end
      end
      OP_SET: begin
        if (!busy) begin
          pos_next          = tgt_w;
          res_next.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_next.steps_left = rem_next;
    res_next.moving_up  = dir_next;
    res_next.position   = pos_x[31:0];
  end

  assign pos_x = {{32{pos_next[PW-1]}}, pos_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      rem       <= '0;
      dir       <= 1'b1;
      prev_sw   <= 1'b0;
      last_lim  <= LIM_NONE;
      res_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        pos      <= pos_next;
        rem      <= rem_next;
        dir      <= dir_next;
        prev_sw  <= prev_sw_next;
        last_lim <= last_lim_next;
      end
      if (q_pop) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/axis_position_limit_guard.sv =====
// Top level of the axis position limit guard: config registers, front end,
// item queue and back end. Depends on aplg_pkg, aplg_front, aplg_fifo, aplg_back.
//
//   channel  signals                     dir  payload
//   cmd      cmd_valid / cmd_stall       in   aplg_pkg::in_t
//   res      res_valid / res_stall       out  aplg_pkg::out_t
//   cfg      cfg_we / cfg_index          in   cfg_data, 32 bit
//
// One item per cycle sustained while res_stall is low; a taken item is first
// written into the queue, then the back end executes it into the result register.
// The back end updates position state once per cycle unless stalled,
// which sets the rate.
// rst is synchronous: state clears, position 0, direction up, queue empty.
// cmd_stall rises only when the two-entry queue is full; res_stall holds
// the result register and the queue absorbs up to two more items.
module axis_position_limit_guard #(
  parameter int POS_WIDTH = aplg_pkg::POS_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  aplg_pkg::in_t  cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output aplg_pkg::out_t res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import aplg_pkg::*;

  cfg_t cfg;
  cmd_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOFT_MIN:        cfg.soft_min        <= cfg_data;
        REG_SOFT_MAX:        cfg.soft_max        <= cfg_data;
        REG_SOFT_ENABLE:     cfg.soft_enable     <= cfg_data[0];
        REG_HARD_MIN:        cfg.hard_min        <= cfg_data;
        REG_HARD_MAX:        cfg.hard_max        <= cfg_data;
        REG_LIMIT_MODE:      cfg.limit_mode      <= cfg_data[1:0];
        REG_ACTIVE_LEVEL:    cfg.active_level    <= cfg_data[0];
        REG_SWITCHES_FITTED: cfg.switches_fitted <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  aplg_front u_front (
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  aplg_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  aplg_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== rtl/aplg_checker.sv =====
// Port-level checks for the axis position limit guard, bound to the top.
// Depends on aplg_pkg and axis_position_limit_guard_macros.svh.
`include "axis_position_limit_guard_macros.svh"

module aplg_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input aplg_pkg::out_t res
);
  import aplg_pkg::*;

  // a stalled result holds
  `APLG_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))

  // a limit stop empties the move and reports a nonzero cut
  `APLG_ASSERT_NOW(a_stop_cut, clk, rst, res_valid && (res.limit_hit != LIM_NONE), (res.steps_left == '0) && (res.steps_cut != '0))

  // no stop, nothing cut
  `APLG_ASSERT_NOW(a_no_cut, clk, rst, res_valid && (res.limit_hit == LIM_NONE), res.steps_cut == '0)

  // accepted moves and sets never coincide with a limit stop
  `APLG_ASSERT_NOW(a_acc_excl, clk, rst, res_valid && res.accepted, res.limit_hit == LIM_NONE)

endmodule

bind axis_position_limit_guard aplg_checker u_aplg_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for axis_position_limit_guard: random and directed items,
// predicted results checked in order by a scoreboard class. Depends on aplg_pkg and the guard top.
module testbench;
  import aplg_pkg::*;

  class axis_scoreboard;
    cfg_t               regs;
    logic signed [31:0] pos;
    logic [31:0]        rem;
    logic               dir_up;
    logic               prev_sw;
    logic [1:0]         last_lim;
    out_t               expected_reports[$];
    int                 mismatches;

    function new();
      regs = '0;
      pos = 0;
      rem = 0;
      dir_up = 1'b1;
      prev_sw = 1'b0;
      last_lim = LIM_NONE;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_SOFT_MIN:        regs.soft_min = d;
        REG_SOFT_MAX:        regs.soft_max = d;
        REG_SOFT_ENABLE:     regs.soft_enable = d[0];
        REG_HARD_MIN:        regs.hard_min = d;
        REG_HARD_MAX:        regs.hard_max = d;
        REG_LIMIT_MODE:      regs.limit_mode = d[1:0];
        REG_ACTIVE_LEVEL:    regs.active_level = d[0];
        REG_SWITCHES_FITTED: regs.switches_fitted = d[1:0];
        default: ;
      endcase
    endfunction

    // new move from the current position; distance saturates at 32 bits
    function void head_to(logic signed [31:0] goal);
      longint p, g, d;
      p = pos;
      g = goal;
      if (g < p) begin
        dir_up = 1'b0;
        d = p - g;
      end else begin
        dir_up = 1'b1;
        d = g - p;
      end
      rem = (d > 64'd4294967295) ? 32'hFFFF_FFFF : d[31:0];
    endfunction

    function out_t predict_report(in_t c);
      out_t               r;
      logic signed [31:0] t;
      logic               on, want_up, want_dn;
      r = '0;
      t = c.target_pos;
      want_up = 1'b0;
      want_dn = 1'b0;
      case (c.operation)
        OP_STEP: begin
          if (rem != 0) begin
            rem = rem - 1;
            pos = dir_up ? pos + 1 : pos - 1;
          end
        end
        OP_POLL: begin
          if (regs.limit_mode == MODE_SHARED) begin
            on = (c.up_level == regs.active_level);
            if (on && !prev_sw) begin
              if (dir_up) want_up = 1'b1;
              else want_dn = 1'b1;
            end else if (on) begin
              // held switch: re-apply whichever limit stopped us last
              want_up = (last_lim == LIM_UP);
              want_dn = (last_lim == LIM_DN);
            end
            prev_sw = on;
          end else if (regs.limit_mode == MODE_SEPARATE) begin
            want_up = regs.switches_fitted[0] && (c.up_level == regs.active_level);
            want_dn = regs.switches_fitted[1] && (c.down_level == regs.active_level);
          end
          if (want_up && rem != 0 && dir_up) begin
            r.steps_cut = rem;
            rem = 0;
            pos = regs.hard_max;
            last_lim = LIM_UP;
            r.limit_hit = LIM_UP;
          end
          if (want_dn && rem != 0 && !dir_up) begin
            r.steps_cut = rem;
            rem = 0;
            pos = regs.hard_min;
            last_lim = LIM_DN;
            r.limit_hit = LIM_DN;
          end
        end
        OP_MOVE: begin
          r.accepted = 1'b1;
          if (regs.soft_enable) begin
            // upper test first, so inverted limits resolve toward soft_max
            if (t >= $signed(regs.soft_max)) begin
              if (c.clamp_on_soft) head_to(regs.soft_max);
              else r.accepted = 1'b0;
            end else if (t <= $signed(regs.soft_min)) begin
              if (c.clamp_on_soft) head_to(regs.soft_min);
              else r.accepted = 1'b0;
            end else begin
              head_to(t);
            end
          end else begin
            head_to(t);
          end
        end
        OP_SET: begin
          if (rem == 0) begin
            pos = t;
            r.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      r.position = pos;
      r.steps_left = rem;
      r.moving_up = dir_up;
      return r;
    endfunction

    function void note_command(in_t c);
      expected_reports.push_back(predict_report(c));
    endfunction

    function void flag(string note);
      mismatches++;
      if (mismatches <= 10) $display("%t mismatch: %s", $realtime, note);
    endfunction

    function void check_report(out_t got);
      out_t exp;
      if (expected_reports.size() == 0) begin
        flag($sformatf("unexpected result pos %0d left %0d", got.position, got.steps_left));
        return;
      end
      exp = expected_reports.pop_front();
      if (got.position !== exp.position || got.steps_left !== exp.steps_left ||
          got.moving_up !== exp.moving_up || got.accepted !== exp.accepted ||
          got.limit_hit !== exp.limit_hit || got.steps_cut !== exp.steps_cut)
        flag($sformatf({"exp pos %0d left %0d up %0b acc %0b hit %0d cut %0d / ",
                        "got pos %0d left %0d up %0b acc %0b hit %0d cut %0d"},
                       exp.position, exp.steps_left, exp.moving_up, exp.accepted,
                       exp.limit_hit, exp.steps_cut, got.position, got.steps_left,
                       got.moving_up, got.accepted, got.limit_hit, got.steps_cut));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  in_t         cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  out_t        res;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  axis_scoreboard sb = new();

  axis_position_limit_guard uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.note_command(cmd);
      if (res_valid && !res_stall) sb.check_report(res);
    end
  end

  function automatic in_t cmd_item(op_t op, logic [31:0] tgt, bit clamp, bit up, bit dn);
    in_t it;
    it.operation = op;
    it.target_pos = tgt;
    it.clamp_on_soft = clamp;
    it.up_level = up;
    it.down_level = dn;
    return it;
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return int'($urandom_range(800)) - 400;
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.soft_min = pick_bound();
    c.soft_max = pick_bound();
    c.soft_enable = ($urandom_range(9) < 7);
    c.hard_min = ($urandom_range(3) == 0) ? pick_bound() : int'($urandom_range(200)) - 300;
    c.hard_max = ($urandom_range(3) == 0) ? pick_bound() : int'($urandom_range(200)) + 100;
    c.limit_mode = 2'($urandom_range(3));
    c.active_level = 1'($urandom_range(1));
    c.switches_fitted = 2'($urandom_range(3));
    return c;
  endfunction

  function automatic logic [31:0] near_target(cfg_t c);
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return int'($urandom_range(120)) - 60;
    if (sel < 78) return c.soft_max + int'($urandom_range(2)) - 1;
    if (sel < 86) return c.soft_min + int'($urandom_range(2)) - 1;
    return $urandom();
  endfunction

  task automatic send_cmd(input in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // step the clock first so the last accepted item is already noted
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    put_reg(REG_SOFT_MIN, c.soft_min);
    put_reg(REG_SOFT_MAX, c.soft_max);
    put_reg(REG_SOFT_ENABLE, {31'b0, c.soft_enable});
    put_reg(REG_HARD_MIN, c.hard_min);
    put_reg(REG_HARD_MAX, c.hard_max);
    put_reg(REG_LIMIT_MODE, {30'b0, c.limit_mode});
    put_reg(REG_ACTIVE_LEVEL, {31'b0, c.active_level});
    put_reg(REG_SWITCHES_FITTED, {30'b0, c.switches_fitted});
    cfg_we <= 1'b0;
  endtask

  // mostly move / steps / poll sequences with an optional set, the rest arbitrary items
  task automatic run_random(input int count, input cfg_t c);
    int sent, k;
    in_t it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        it = cmd_item(op_t'($urandom_range(3)), $urandom(), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        send_cmd(it);
        sent++;
      end else begin
        if ($urandom_range(3) == 0) begin
          send_cmd(cmd_item(OP_SET, near_target(c), 1'b0, 1'b0, 1'b0));
          sent++;
        end
        send_cmd(cmd_item(OP_MOVE, near_target(c), 1'($urandom_range(1)), 1'b0, 1'b0));
        sent++;
        k = $urandom_range(40);
        repeat (k) begin
          send_cmd(cmd_item(OP_STEP, $urandom(), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1))));
          sent++;
          if ($urandom_range(9) == 0) begin
            send_cmd(cmd_item(OP_POLL, $urandom(), 1'b0, 1'($urandom_range(1)),
                              1'($urandom_range(1))));
            sent++;
          end
        end
        send_cmd(cmd_item(OP_POLL, $urandom(), 1'b0, 1'($urandom_range(1)),
                          1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  initial begin
    cfg_t c;
    int   ph;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shared switch, soft limits around zero
    c.soft_min = -1000;
    c.soft_max = 1000;
    c.soft_enable = 1'b1;
    c.hard_min = -2000;
    c.hard_max = 2000;
    c.limit_mode = MODE_SHARED;
    c.active_level = 1'b1;
    c.switches_fitted = 2'd3;
    apply_cfg(c);
    send_cmd(cmd_item(OP_STEP, 0, 1'b0, 1'b0, 1'b0));        // step while stopped
    send_cmd(cmd_item(OP_SET, 5, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_MOVE, 20, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_STEP, 0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_STEP, 0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_SET, 100, 1'b0, 1'b0, 1'b0));      // refused while moving
    send_cmd(cmd_item(OP_MOVE, 5000, 1'b0, 1'b0, 1'b0));    // refused by soft limit
    send_cmd(cmd_item(OP_MOVE, 5000, 1'b1, 1'b0, 1'b0));    // clamped up
    send_cmd(cmd_item(OP_MOVE, -5000, 1'b1, 1'b0, 1'b0));   // clamped down
    send_cmd(cmd_item(OP_MOVE, 7, 1'b0, 1'b0, 1'b0));       // zero length
    send_cmd(cmd_item(OP_MOVE, 900, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b1, 1'b0));       // edge, stops upward
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b1, 1'b0));
    send_cmd(cmd_item(OP_MOVE, -500, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b1, 1'b0));       // held, wrong direction
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b1, 1'b0));       // edge, stops downward
    drain();

    // inverted soft limits, unused limit mode, extreme hard limits
    c.soft_min = 100;
    c.soft_max = -100;
    c.hard_min = 32'h8000_0000;
    c.hard_max = 32'h7FFF_FFFF;
    c.limit_mode = 2'd3;
    c.active_level = 1'b0;
    c.switches_fitted = 2'd2;
    apply_cfg(c);
    send_cmd(cmd_item(OP_MOVE, 0, 1'b1, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_MOVE, -500, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b0, 1'b0));
    drain();

    // separate switches, full-range moves
    c.soft_enable = 1'b0;
    c.limit_mode = MODE_SEPARATE;
    c.switches_fitted = 2'd3;
    apply_cfg(c);
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_SET, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_MOVE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_STEP, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b0, 1'b1));
    send_cmd(cmd_item(OP_MOVE, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd_item(OP_POLL, 0, 1'b0, 1'b1, 1'b0));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      c = rand_cfg();
      apply_cfg(c);
      if (ph == 4) hold_req = 300;   // long back-pressure, queue fills up
      run_random(160, c);
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aplg_pkg.sv
rtl/aplg_front.sv
rtl/aplg_fifo.sv
rtl/aplg_back.sv
rtl/axis_position_limit_guard.sv
rtl/aplg_checker.sv
tb/testbench.sv
